@@ rtl/a2u_pkg.sv @@
// a2u_pkg: constants and helper functions for the ascii to u128 parser
// self-contained, used by ascii_to_u128_parser through scoped names

package a2u_pkg;

  // character codes for the hex prefix
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X_LO = 8'h78;
  localparam logic [7:0] CHAR_X_UP = 8'h58;

  // hex digit count limits
  localparam int unsigned HEX_CNT_W      = 6;
  localparam logic [5:0]  HEX_MAX_DIGITS = 6'd32;
  localparam logic [5:0]  HEX_CNT_SAT    = 6'd33;

  // accumulator and result widths
  localparam int unsigned ACC_W  = 128;
  localparam int unsigned HALF_W = 64;

  // decoded hex character
  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } nib_t;

  // hex digit decode, either case
  function automatic nib_t hex_nibble(input logic [7:0] c);
    nib_t n;
    n.bad = 1'b0;
    n.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      n.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      n.val = c[3:0] + 4'd9;
    end else begin
      n.bad = 1'b1;
    end
    return n;
  endfunction

  // decimal digit test
  function automatic logic is_dec(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

endpackage

@@ rtl/ascii_to_u128_parser.sv @@
// ascii_to_u128_parser: decimal or 0x-prefixed hex text to a 128-bit value
// depends on a2u_pkg for character constants and digit decode
//
// Usage: the input stream carries one ASCII character per request in
// in_tdata[7:0]; in_tlast marks the final character of a string. Every
// string gives exactly one result on the output stream: out_tdata holds
// the value (low half in bits 63:0, high half in 127:64) and out_tuser is
// the ok flag. A failed string returns a zero value with out_tuser low.
// Throughput: one character per clock while in_tready is high, strings
// back to back with no gap. Each digit is decoded and folded into the
// 128-bit accumulator in the cycle it is accepted (one shift-add by ten
// or a four-bit shift); the result of the last character is registered
// in the result register, or in the skid register if the receiver stalls.
// Stall: a one-entry skid register behind the result register holds a
// second result while the receiver stalls; in_tready drops only when both
// are full, and characters keep flowing until then.
// Reset (rst_n low, synchronous) clears the accumulator, the parse state
// and both result valid flags; the block is ready on the next cycle.

module ascii_to_u128_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  input  logic         in_tlast,   // last_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] value_low, [127:64] value_high
  output logic         out_tuser   // [0] parse_ok
);

  localparam int unsigned AW = a2u_pkg::ACC_W;

  // parse state
  logic [AW-1:0]                  acc_r, acc_nxt;
  logic [1:0]                     pos_r, pos_nxt;
  logic                           fz_r, fz_nxt;
  logic                           hex_r, hex_nxt;
  logic [a2u_pkg::HEX_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           fail_r, fail_nxt;

  // result and skid slots
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_data_r, out_data_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [AW-1:0] skid_data_r, skid_data_nxt;
  logic          skid_ok_r, skid_ok_nxt;

  logic          in_fire;
  logic          res_fire;
  logic          prefix;
  logic          res_ok;
  logic [AW-1:0] res_val;
  logic [AW-1:0] acc_x10;
  a2u_pkg::nib_t nib;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign res_fire   = in_fire && in_tlast;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // character decode and accumulator update
  always_comb begin
    nib      = a2u_pkg::hex_nibble(in_tdata);
    acc_x10  = {acc_r[AW-4:0], 3'b000} + {acc_r[AW-2:0], 1'b0}
               + {{(AW-4){1'b0}}, in_tdata[3:0]};
    pos_nxt  = (pos_r < 2'd2) ? pos_r + 2'd1 : pos_r;
    fz_nxt   = (pos_r == 2'd0) ? (in_tdata == a2u_pkg::CHAR_ZERO) : fz_r;
    prefix   = (pos_r == 2'd1) && fz_r &&
               ((in_tdata == a2u_pkg::CHAR_X_LO) || (in_tdata == a2u_pkg::CHAR_X_UP));
    hex_nxt  = hex_r;
    fail_nxt = fail_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (prefix) begin
      hex_nxt = 1'b1;
    end else if (!fail_r) begin
      if (hex_r) begin
        if (nib.bad) begin
          fail_nxt = 1'b1;
        end else begin
          if (cnt_r < a2u_pkg::HEX_CNT_SAT) cnt_nxt = cnt_r + 6'd1;
          acc_nxt = {acc_r[AW-5:0], nib.val};
        end
      end else begin
        if (!a2u_pkg::is_dec(in_tdata)) begin
          fail_nxt = 1'b1;
        end else begin
          acc_nxt = acc_x10;
        end
      end
    end
    // final verdict on the string
    res_ok = !fail_nxt &&
             !(hex_nxt && ((cnt_nxt == '0) || (cnt_nxt > a2u_pkg::HEX_MAX_DIGITS)));
    res_val = res_ok ? acc_nxt : '0;
  end

  // parse state registers, cleared after each string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= '0;
      fz_r   <= 1'b0;
      hex_r  <= 1'b0;
      cnt_r  <= '0;
      fail_r <= 1'b0;
    end else if (in_fire) begin
      if (in_tlast) begin
        acc_r  <= '0;
        pos_r  <= '0;
        fz_r   <= 1'b0;
        hex_r  <= 1'b0;
        cnt_r  <= '0;
        fail_r <= 1'b0;
      end else begin
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
        fz_r   <= fz_nxt;
        hex_r  <= hex_nxt;
        cnt_r  <= cnt_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  // result register and skid slot steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_ok_nxt     = out_ok_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_ok_nxt    = skid_ok_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_ok_nxt     = skid_ok_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_fire;
        out_data_nxt  = res_val;
        out_ok_nxt    = res_ok;
      end
    end else if (res_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_val;
      skid_ok_nxt    = res_ok;
    end
  end

  // result valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_ok_r    <= out_ok_nxt;
    skid_data_r <= skid_data_nxt;
    skid_ok_r   <= skid_ok_nxt;
  end

  // skid slot only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot valid while result register empty");

  // a stalled receiver keeps the skid entry in place
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> skid_valid_r)
    else $error("skid entry lost during stall");

  // parse state is clear after the last character of a string
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> ((acc_r == '0) && (pos_r == 2'd0) && !hex_r && !fail_r))
    else $error("parse state not cleared after string end");

  // digit count moves only in hex mode
  a_cnt_hex_only: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> hex_r)
    else $error("hex digit count nonzero outside hex mode");

  // a failed result carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("failed result with nonzero value");

endmodule
